[rtl/nnc_pkg.sv]
// Shared types and constants of the nearest neighbor classifier.
// Op codes, status codes, fixed field widths and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package nnc_pkg;

    localparam int LIMIT_W  = 22;
    localparam int LABEL_W  = 2;
    localparam int STATUS_W = 3;
    localparam int NUM_FEAT = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 22'd2560000;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_QUERY = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_STORED     = 3'd0;
    localparam t_status ST_FULL       = 3'd1;
    localparam t_status ST_CLASSIFIED = 3'd2;
    localparam t_status ST_NONE       = 3'd3;
    localparam t_status ST_CLEARED    = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the input transaction
        logic scan_en;  // issue one table read
        logic finish;   // apply op and load the output register
    } t_nnc_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic empty;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_nnc_sts;

endpackage

[rtl/nnc_if.sv]
// Channel interfaces of the nearest neighbor classifier (valid/ready).
// Depends on nnc_pkg for field widths.
`timescale 1ns / 1ps

interface nnc_in_if #(
    parameter int FEATURE_BITS = 10
);
    import nnc_pkg::*;

    logic                    valid;
    logic                    ready;
    t_op                     op;
    logic [FEATURE_BITS-1:0] feature_sepal_length;
    logic [FEATURE_BITS-1:0] feature_sepal_width;
    logic [FEATURE_BITS-1:0] feature_petal_length;
    logic [FEATURE_BITS-1:0] feature_petal_width;
    logic [LABEL_W-1:0]      class_label;

    modport source (
        output valid, op, feature_sepal_length, feature_sepal_width,
               feature_petal_length, feature_petal_width, class_label,
        input  ready
    );
    modport sink (
        input  valid, op, feature_sepal_length, feature_sepal_width,
               feature_petal_length, feature_petal_width, class_label,
        output ready
    );
endinterface

interface nnc_out_if;
    import nnc_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [LABEL_W-1:0] predicted_label;
    logic [LIMIT_W-1:0] best_distance_sq;
    logic               mismatch;

    modport source (
        output valid, status, predicted_label, best_distance_sq, mismatch,
        input  ready
    );
    modport sink (
        input  valid, status, predicted_label, best_distance_sq, mismatch,
        output ready
    );
endinterface

[rtl/nnc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module nnc_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/nnc_ctrl.sv]
// Controller of the nearest neighbor classifier: sequences decode, table scan,
// pipeline drain and result write. Depends on nnc_pkg.
`timescale 1ns / 1ps

module nnc_ctrl
    import nnc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_nnc_sts i_sts,
    output logic     o_in_ready,
    output t_nnc_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_LOAD:  n_state = S_FINISH;
                    OP_CLEAR: n_state = S_FINISH;
                    OP_QUERY: n_state = i_sts.empty ? S_FINISH : S_SCAN;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan_en = (r_state == S_SCAN);
    assign o_cmd.finish  = (r_state == S_FINISH) && i_sts.out_free;

endmodule

[rtl/nnc_datapath.sv]
// Datapath of the nearest neighbor classifier: training table, distance
// pipeline, best-match tracking, limit register and output register.
// Depends on nnc_pkg and nnc_ram.
`timescale 1ns / 1ps

module nnc_datapath
    import nnc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 128,
    parameter int FEATURE_BITS  = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_nnc_cmd                i_cmd,
    output t_nnc_sts                o_sts,
    input  t_op                     i_op,
    input  logic [FEATURE_BITS-1:0] i_feature_sepal_length,
    input  logic [FEATURE_BITS-1:0] i_feature_sepal_width,
    input  logic [FEATURE_BITS-1:0] i_feature_petal_length,
    input  logic [FEATURE_BITS-1:0] i_feature_petal_width,
    input  logic [LABEL_W-1:0]      i_class_label,
    input  logic                    i_cfg_we,
    input  logic [LIMIT_W-1:0]      i_cfg_data,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output t_status                 o_status,
    output logic [LABEL_W-1:0]      o_predicted_label,
    output logic [LIMIT_W-1:0]      o_best_distance_sq,
    output logic                    o_mismatch
);

    localparam int AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = NUM_FEAT * FEATURE_BITS + LABEL_W;
    localparam int SQ_W    = 2 * FEATURE_BITS;
    localparam int SUM_W   = SQ_W + 2;
    localparam int CMP_W   = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    // latched transaction
    t_op                     r_op;
    logic [FEATURE_BITS-1:0] r_q [NUM_FEAT];
    logic [LABEL_W-1:0]      r_label;

    logic [LIMIT_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_count;
    logic [AW-1:0]      r_scan_addr;

    // distance pipeline
    logic               r_v0, r_v1, r_v2;
    logic [SQ_W-1:0]    r_sq [NUM_FEAT];
    logic [LABEL_W-1:0] r_lbl1, r_lbl2;
    logic [SUM_W-1:0]   r_sum;

    logic [LIMIT_W-1:0] r_best;
    logic [LABEL_W-1:0] r_best_lbl;
    logic               r_found;

    logic [ENTRY_W-1:0]      rd_data;
    logic [ENTRY_W-1:0]      wr_data;
    logic                    wr_en;
    logic                    full;
    logic                    out_free;
    logic [SQ_W-1:0]         sq [NUM_FEAT];
    logic [FEATURE_BITS-1:0] ent;
    logic [FEATURE_BITS-1:0] diff;
    logic [SUM_W-1:0]        sum;
    logic                    better;

    assign full     = (r_count == CNT_W'(TABLE_ENTRIES));
    assign out_free = !o_out_valid || i_out_ready;
    assign wr_en    = i_cmd.finish && (r_op == OP_LOAD) && !full;
    assign wr_data  = {r_label, r_q[3], r_q[2], r_q[1], r_q[0]};

    nnc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.scan_en),
        .i_rd_addr (r_scan_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        ent  = '0;
        diff = '0;
        for (int k = 0; k < NUM_FEAT; k++) begin
            ent   = rd_data[k*FEATURE_BITS +: FEATURE_BITS];
            diff  = (r_q[k] >= ent) ? (r_q[k] - ent) : (ent - r_q[k]);
            sq[k] = {{FEATURE_BITS{1'b0}}, diff} * {{FEATURE_BITS{1'b0}}, diff};
        end
    end

    assign sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]) + SUM_W'(r_sq[3]);
    assign better = r_v2 && (CMP_W'(r_sum) < CMP_W'(r_best));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_scan_addr <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_found     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            r_v0 <= i_cmd.scan_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (i_cmd.capture) begin
                r_scan_addr <= '0;
                r_found     <= 1'b0;
            end else begin
                if (i_cmd.scan_en) r_scan_addr <= r_scan_addr + AW'(1);
                if (better) r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                o_out_valid <= 1'b1;
                if (wr_en) r_count <= r_count + CNT_W'(1);
                if (r_op == OP_CLEAR) r_count <= '0;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_q[0]  <= i_feature_sepal_length;
            r_q[1]  <= i_feature_sepal_width;
            r_q[2]  <= i_feature_petal_length;
            r_q[3]  <= i_feature_petal_width;
            r_label <= i_class_label;
            r_best  <= r_limit;
        end else if (better) begin
            // strict compare keeps the first entry on a tie
            r_best     <= LIMIT_W'(r_sum);
            r_best_lbl <= r_lbl2;
        end
        r_sq   <= sq;
        r_lbl1 <= rd_data[NUM_FEAT*FEATURE_BITS +: LABEL_W];
        r_sum  <= sum;
        r_lbl2 <= r_lbl1;
        if (i_cmd.finish) begin
            o_predicted_label  <= '0;
            o_best_distance_sq <= '0;
            o_mismatch         <= 1'b0;
            case (r_op)
                OP_LOAD:  o_status <= full ? ST_FULL : ST_STORED;
                OP_CLEAR: o_status <= ST_CLEARED;
                OP_QUERY: begin
                    if (r_found) begin
                        o_status           <= ST_CLASSIFIED;
                        o_predicted_label  <= r_best_lbl;
                        o_best_distance_sq <= r_best;
                        o_mismatch         <= (r_best_lbl != r_label);
                    end else begin
                        o_status <= ST_NONE;
                    end
                end
                default:  o_status <= ST_STORED;
            endcase
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_last = (CNT_W'(r_scan_addr) == (r_count - CNT_W'(1)));
    assign o_sts.pipe_busy = r_v0 || r_v1 || r_v2;
    assign o_sts.out_free  = out_free;

endmodule

[rtl/nearest_neighbor_classifier.sv]
// Top level of the one-nearest-neighbor classifier (squared Euclidean distance).
// Depends on nnc_pkg, nnc_if, nnc_ctrl, nnc_datapath, nnc_ram.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  i_in     | in  | valid/ready         | op, four features, class_label
//  o_out    | out | valid/ready         | status, predicted_label, best_distance_sq,
//           |     |                     | mismatch
//  cfg      | in  | i_cfg_we            | i_cfg_data = distance_limit_sq
//
// Load and clear pass through decode to the result write; op 3 returns to idle and gives none.
// A query on an empty table goes straight to the result write; otherwise the table RAM is read
// one entry per cycle, then three pipeline stages (squares, sum, compare) drain.
// Reset empties the table and loads the limit 2560000; the table memory is not cleared.
// A held result stalls the block only when the next result is ready to be written.
`timescale 1ns / 1ps

module nearest_neighbor_classifier
    import nnc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 128,
    parameter int FEATURE_BITS  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nnc_in_if.sink             i_in,
    nnc_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    t_nnc_cmd cmd;
    t_nnc_sts sts;

    nnc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    nnc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FEATURE_BITS  (FEATURE_BITS)
    ) u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_op                   (i_in.op),
        .i_feature_sepal_length (i_in.feature_sepal_length),
        .i_feature_sepal_width  (i_in.feature_sepal_width),
        .i_feature_petal_length (i_in.feature_petal_length),
        .i_feature_petal_width  (i_in.feature_petal_width),
        .i_class_label          (i_in.class_label),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_data             (i_cfg_data),
        .i_out_ready            (o_out.ready),
        .o_out_valid            (o_out.valid),
        .o_status               (o_out.status),
        .o_predicted_label      (o_out.predicted_label),
        .o_best_distance_sq     (o_out.best_distance_sq),
        .o_mismatch             (o_out.mismatch)
    );

    // one transaction in flight at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item is in flight");

    // only a classified result carries label, distance and mismatch
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_CLASSIFIED) |->
        (o_out.predicted_label == '0 && o_out.best_distance_sq == '0 && !o_out.mismatch))
        else $error("nonzero payload on a non-classified result");

    // a new result is written only from the finish state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result produced while the controller was idle");

endmodule
